/* design/assert_macros.svh */
// Assertion macros used by the tracker top level.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define BPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* design/bpt_pkg.sv */
// Types, widths and codes for the backlash position tracker.
// No dependencies; imported by every module and interface of the block.
package bpt_pkg;

    localparam int DIST_W     = 7;
    localparam int BW_W       = 7;
    localparam int MAXPOS_W   = 15;
    localparam int POS_W      = 16;
    localparam int PHASE_W    = 8;
    localparam int MOVE_W     = 8;
    // offset spans -127 .. 253
    localparam int OFS_W      = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;

    localparam logic [MAXPOS_W-1:0] MAX_POSITION_RESET = 15'h7FFF;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BACKLASH_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_POSITION   = 1'd1;

    // command codes
    localparam logic CMD_STEP        = 1'b0;
    localparam logic CMD_CLEAR_PHASE = 1'b1;

    typedef struct packed {
        logic              command;
        logic [DIST_W-1:0] step_dist;
        logic              forward;
        logic              moving_normally;
        logic              ignore_bounds;
    } step_word_t;

    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [PHASE_W-1:0] phase;
        logic [MOVE_W-1:0]  applied_move;
        logic               limit_fault;
    } result_word_t;

    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [PHASE_W-1:0] phase;
        logic [OFS_W-1:0]   offset;
    } track_state_t;

    typedef struct packed {
        logic [BW_W-1:0]     backlash_width;
        logic [MAXPOS_W-1:0] max_position;
    } cfg_t;

endpackage

/* design/bpt_if.sv */
// Valid/ready channel interfaces for step words and result words.
// Depends on bpt_pkg for field widths.
interface bpt_step_if
    import bpt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              command;
    logic [DIST_W-1:0] step_dist;
    logic              forward;
    logic              moving_normally;
    logic              ignore_bounds;

    modport source (
        output valid, command, step_dist, forward, moving_normally, ignore_bounds,
        input  ready
    );
    modport sink (
        input  valid, command, step_dist, forward, moving_normally, ignore_bounds,
        output ready
    );
endinterface

interface bpt_result_if
    import bpt_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [POS_W-1:0]   position;
    logic [PHASE_W-1:0]        phase;
    logic signed [MOVE_W-1:0]  applied_move;
    logic                      limit_fault;

    modport source (
        output valid, position, phase, applied_move, limit_fault,
        input  ready
    );
    modport sink (
        input  valid, position, phase, applied_move, limit_fault,
        output ready
    );
endinterface

/* design/bpt_cfg.sv */
// Configuration registers: backlash width and position upper bound.
// Depends on bpt_pkg.
module bpt_cfg
    import bpt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_BACKLASH_WIDTH: cfg_next.backlash_width = cfg_wdata[BW_W-1:0];
                CFG_MAX_POSITION:   cfg_next.max_position   = cfg_wdata[MAXPOS_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.backlash_width <= '0;
            cfg_reg.max_position   <= MAX_POSITION_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/bpt_step_logic.sv */
// Combinational step update: phase, backlash dead zone, position, bounds check.
// Depends on bpt_pkg.
module bpt_step_logic
    import bpt_pkg::*;
(
    input  step_word_t   item,
    input  track_state_t cur,
    input  cfg_t         cfg,
    output track_state_t nxt,
    output result_word_t res
);

    logic signed [DIST_W+1:0] s;
    logic signed [DIST_W+1:0] d_s;
    logic signed [DIST_W+1:0] w_s;
    logic signed [DIST_W+1:0] w_minus_d;
    logic signed [OFS_W-1:0]  b;
    logic signed [OFS_W-1:0]  w_ofs;
    logic signed [OFS_W:0]    b_sum;
    logic signed [OFS_W:0]    w_wide;
    logic signed [OFS_W:0]    b_excess;
    logic signed [DIST_W+1:0] mv;
    logic [OFS_W-1:0]         ofs_new;
    logic [POS_W-1:0]         pos_new;
    logic                     w_on;

    // raw signed distance and helpers
    always_comb
    begin
        d_s       = $signed({2'b00, item.step_dist});
        w_s       = $signed({2'b00, cfg.backlash_width});
        s         = item.forward ? d_s : -d_s;
        w_minus_d = w_s - d_s;
        b         = $signed(cur.offset);
        w_ofs     = $signed({{(OFS_W-BW_W){1'b0}}, cfg.backlash_width});
        w_wide    = $signed({{(OFS_W+1-BW_W){1'b0}}, cfg.backlash_width});
        b_sum     = $signed({b[OFS_W-1], b}) + $signed({{(OFS_W-DIST_W-1){s[DIST_W+1]}}, s});
        b_excess  = b_sum - w_wide;
        w_on      = (cfg.backlash_width != '0);
    end

    // dead zone
    always_comb
    begin
        mv      = s;
        ofs_new = cur.offset;
        if (w_on && (b < 0) && item.forward)
        begin
            // leaving the zone forward: take up the full width
            ofs_new = {{(OFS_W-DIST_W){1'b0}}, item.step_dist};
            mv      = (w_minus_d > 0) ? '0 : -w_minus_d;
        end
        else if (w_on && (b >= w_ofs) && !item.forward)
        begin
            // leaving the zone backward
            ofs_new = {{(OFS_W-DIST_W-2){w_minus_d[DIST_W+1]}}, w_minus_d};
            mv      = (w_minus_d > 0) ? '0 : w_minus_d;
        end
        else if (w_on && (b >= 0) && (b < w_ofs))
        begin
            // inside the zone: move only the part that spills over
            ofs_new = b_sum[OFS_W-1:0];
            if (b_sum < 0)
                mv = b_sum[DIST_W+1:0];
            else if (b_sum >= w_wide)
                mv = b_excess[DIST_W+1:0];
            else
                mv = '0;
        end
    end

    // position, phase and result
    always_comb
    begin
        pos_new = cur.position + {{(POS_W-MOVE_W){mv[MOVE_W-1]}}, mv[MOVE_W-1:0]};
        nxt = cur;
        res.position     = cur.position;
        res.phase        = '0;
        res.applied_move = '0;
        res.limit_fault  = 1'b0;
        if (item.command == CMD_CLEAR_PHASE)
        begin
            nxt.phase = '0;
        end
        else
        begin
            nxt.phase    = cur.phase + s[PHASE_W-1:0];
            nxt.offset   = ofs_new;
            nxt.position = pos_new;
            res.position     = pos_new;
            res.phase        = nxt.phase;
            res.applied_move = mv[MOVE_W-1:0];
            res.limit_fault  = item.moving_normally && !item.ignore_bounds &&
                               (pos_new[POS_W-1] ||
                                (pos_new[MAXPOS_W-1:0] >= cfg.max_position));
        end
    end

endmodule

/* design/backlash_position_tracker.sv */
// Top level of the backlash position tracker: input register, state, result register.
// Depends on bpt_pkg, bpt_if, bpt_cfg, bpt_step_logic and assert_macros.svh.
//
// Each accepted step word gives exactly one result word: the word is captured in an
// input register, passes once through the dead-zone and position-add logic (one
// combinational pass through the 16-bit position add and bounds compare), and lands
// in a result register together with the tracker state update. One word is taken
// every cycle while results are read as they appear. The input register frees
// whenever the result register is empty or being read; a result left waiting holds
// the input register, so at most one more word is taken behind it until the result
// is read.
// Configuration writes take effect the cycle after cfg_we and must be made while no
// word is in flight.
`include "assert_macros.svh"

module backlash_position_tracker
    import bpt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    bpt_step_if.sink              step_ch,
    bpt_result_if.source          res_ch
);

    cfg_t         cfg;
    step_word_t   in_word_reg;
    logic         in_valid_reg;
    track_state_t state_reg;
    track_state_t state_next;
    result_word_t res_reg;
    result_word_t res_next;
    logic         res_valid_reg;
    logic         advance;
    logic         take;

    bpt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bpt_step_logic u_step (
        .item (in_word_reg),
        .cur  (state_reg),
        .cfg  (cfg),
        .nxt  (state_next),
        .res  (res_next)
    );

    // handshake control
    assign advance       = in_valid_reg && (!res_valid_reg || res_ch.ready);
    assign step_ch.ready = !in_valid_reg || advance;
    assign take          = step_ch.valid && step_ch.ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (step_ch.ready)
            in_valid_reg <= step_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_word_reg.command         <= step_ch.command;
            in_word_reg.step_dist       <= step_ch.step_dist;
            in_word_reg.forward         <= step_ch.forward;
            in_word_reg.moving_normally <= step_ch.moving_normally;
            in_word_reg.ignore_bounds   <= step_ch.ignore_bounds;
        end
    end

    // tracker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
            state_reg <= state_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= 1'b1;
        else if (res_ch.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign res_ch.valid        = res_valid_reg;
    assign res_ch.position     = $signed(res_reg.position);
    assign res_ch.phase        = res_reg.phase;
    assign res_ch.applied_move = $signed(res_reg.applied_move);
    assign res_ch.limit_fault  = res_reg.limit_fault;

    // checks
    `BPT_ASSERT_IMP(a_offset_range, clk, rst_n, 1'b1, ($signed(state_reg.offset) >= -10'sd127) && ($signed(state_reg.offset) <= 10'sd253))
    `BPT_ASSERT_IMP(a_result_tracks_state, clk, rst_n, res_valid_reg, (res_reg.position == state_reg.position) && ((res_reg.phase == state_reg.phase) || (state_reg.phase == '0)))
    `BPT_ASSERT_NEXT(a_advance_fills_result, clk, rst_n, advance, res_valid_reg)
    `BPT_ASSERT_NEXT(a_held_word_kept, clk, rst_n, in_valid_reg && !advance, in_valid_reg)

endmodule

/* bench/testbench.sv */
// Self-checking bench for the backlash position tracker: a directed table, then
// random moves checked word by word against a local model. Needs bpt_pkg, bpt_if and the RTL.
module testbench
    import bpt_pkg::*;
();

    localparam int RANDOM_WORDS = 1750;
    localparam int STALL_LIMIT  = 1000;
    localparam int IDLE_PCT     = 18;
    localparam logic DIR_FWD    = 1'b1;
    localparam logic DIR_BWD    = 1'b0;

    typedef enum logic {ROW_STEP, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        step_word_t             word;
        logic                   typed;
        result_word_t           want;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    bpt_step_if   step_ch ();
    bpt_result_if res_ch ();

    backlash_position_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .step_ch   (step_ch),
        .res_ch    (res_ch)
    );

    // local copy of tracker state and register settings
    logic [POS_W-1:0]   trk_pos;
    logic [PHASE_W-1:0] trk_phase;
    int                 slack;
    int                 cfg_bw;
    int                 cfg_maxpos;

    result_word_t pending_results[$];
    dir_row_t     directed_rows[$];

    bit calm;
    int mismatches;
    int n_checked;
    int n_steps;
    int n_clears;
    int n_writes;
    int n_errors;
    int n_absorbed;
    int stall_cycles;

    always #5 clk = ~clk;

    // Apply one word to the local tracker and return the result it should give
    function automatic result_word_t advance_tracker(step_word_t w);
        int s;
        int mv;
        int pos_s;
        result_word_t r;
        mv = 0;
        r.limit_fault = 1'b0;
        if (w.command == CMD_CLEAR_PHASE)
        begin
            trk_phase = '0;
        end
        else
        begin
            s = w.forward ? int'(w.step_dist) : -int'(w.step_dist);
            trk_phase = trk_phase + s[PHASE_W-1:0];
            mv = s;
            // dead zone: reversal eats up to bw microsteps of travel
            if (cfg_bw != 0)
            begin
                if (slack < 0 && w.forward)
                begin
                    slack = int'(w.step_dist);
                    mv = (s - cfg_bw < 0) ? 0 : s - cfg_bw;
                end
                else if (slack >= cfg_bw && !w.forward)
                begin
                    slack = cfg_bw - int'(w.step_dist);
                    mv = (s + cfg_bw > 0) ? 0 : s + cfg_bw;
                end
                else if (slack >= 0 && slack < cfg_bw)
                begin
                    slack = slack + s;
                    if (slack < 0)
                        mv = slack;
                    else if (slack >= cfg_bw)
                        mv = slack - cfg_bw;
                    else
                        mv = 0;
                end
            end
            trk_pos = trk_pos + mv[POS_W-1:0];
            pos_s = int'($signed(trk_pos));
            r.limit_fault = w.moving_normally && !w.ignore_bounds &&
                            (pos_s < 0 || pos_s >= cfg_maxpos);
        end
        r.position     = trk_pos;
        r.phase        = trk_phase;
        r.applied_move = mv[MOVE_W-1:0];
        return r;
    endfunction

    function automatic void add_step(step_word_t w, logic typed, result_word_t want);
        dir_row_t row;
        row.kind    = ROW_STEP;
        row.word    = w;
        row.typed   = typed;
        row.want    = want;
        row.reg_idx = '0;
        row.reg_val = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        dir_row_t row;
        row.kind    = ROW_REG;
        row.word    = '0;
        row.typed   = 1'b0;
        row.want    = '0;
        row.reg_idx = idx;
        row.reg_val = val;
        directed_rows.push_back(row);
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    // Offer one step word, with random idle cycles ahead of it
    task automatic send_word(step_word_t w, logic typed, result_word_t want);
        result_word_t due;
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            step_ch.valid <= 1'b0;
            @(posedge clk);
        end
        step_ch.valid           <= 1'b1;
        step_ch.command         <= w.command;
        step_ch.step_dist       <= w.step_dist;
        step_ch.forward         <= w.forward;
        step_ch.moving_normally <= w.moving_normally;
        step_ch.ignore_bounds   <= w.ignore_bounds;
        do
            @(posedge clk);
        while (!step_ch.ready);
        due = advance_tracker(w);
        if (w.command == CMD_CLEAR_PHASE)
            n_clears++;
        else
            n_steps++;
        if (w.command == CMD_STEP && w.step_dist != 0 && due.applied_move == 0)
            n_absorbed++;
        n_errors += due.limit_fault;
        pending_results.push_back(typed ? want : due);
    endtask

    // Hold the sender off until every pending result is back
    task automatic wait_drained();
        step_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_BACKLASH_WIDTH)
            cfg_bw = int'(val[BW_W-1:0]);
        else if (idx == CFG_MAX_POSITION)
            cfg_maxpos = int'(val[MAXPOS_W-1:0]);
        n_writes++;
    endtask

    // Result side: random back-pressure, compare each word with the oldest prediction
    always @(posedge clk)
    begin : result_check
        result_word_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("result word with nothing pending, position %0d",
                                          res_ch.position));
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_ch.position !== want.position)
                    report_mismatch($sformatf("result %0d position got %0d want %0d",
                                              n_checked, res_ch.position,
                                              $signed(want.position)));
                if (res_ch.phase !== want.phase)
                    report_mismatch($sformatf("result %0d phase got %0d want %0d",
                                              n_checked, res_ch.phase, want.phase));
                if (res_ch.applied_move !== want.applied_move)
                    report_mismatch($sformatf("result %0d applied_move got %0d want %0d",
                                              n_checked, res_ch.applied_move,
                                              $signed(want.applied_move)));
                if (res_ch.limit_fault !== want.limit_fault)
                    report_mismatch($sformatf("result %0d limit_fault got %b want %b",
                                              n_checked, res_ch.limit_fault,
                                              want.limit_fault));
                n_checked++;
            end
        end
        res_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog on cycles with no traffic on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (step_ch.valid && step_ch.ready) || (res_ch.valid && res_ch.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles, %0d results pending",
                     STALL_LIMIT, pending_results.size());
            $display("[backlash_position_tracker] ERROR");
            $finish;
        end
    end

    initial
    begin
        int seg;
        int sent;
        int seg_len;
        int pause_at;
        int run_left;
        int cap;
        logic drift;
        logic dir;
        bit sprint;
        step_word_t w;
        logic [CFG_DATA_W-1:0] val;

        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = '0;
        cfg_wdata               = '0;
        step_ch.valid           = 1'b0;
        step_ch.command         = CMD_STEP;
        step_ch.step_dist       = '0;
        step_ch.forward         = DIR_FWD;
        step_ch.moving_normally = 1'b0;
        step_ch.ignore_bounds   = 1'b0;
        res_ch.ready            = 1'b0;
        trk_pos    = '0;
        trk_phase  = '0;
        slack      = 0;
        cfg_bw     = 0;
        cfg_maxpos = int'(MAX_POSITION_RESET);
        calm       = 1'b0;
        mismatches = 0;

        // Directed table: reset state, wraps, bound of zero and one, dead zone entry and exit
        add_step({CMD_CLEAR_PHASE, 7'd0, DIR_FWD, 1'b1, 1'b0}, 1'b1,
                 {16'h0000, 8'h00, 8'h00, 1'b0});
        add_step({CMD_STEP, 7'd127, DIR_FWD, 1'b1, 1'b0}, 1'b1,
                 {16'h007F, 8'h7F, 8'h7F, 1'b0});
        add_step({CMD_STEP, 7'd127, DIR_BWD, 1'b1, 1'b0}, 1'b1,
                 {16'h0000, 8'h00, 8'h81, 1'b0});
        add_step({CMD_STEP, 7'd1, DIR_BWD, 1'b1, 1'b0}, 1'b1,
                 {16'hFFFF, 8'hFF, 8'hFF, 1'b1});
        add_step({CMD_STEP, 7'd1, DIR_BWD, 1'b1, 1'b1}, 1'b1,
                 {16'hFFFE, 8'hFE, 8'hFF, 1'b0});
        add_step({CMD_STEP, 7'd1, DIR_BWD, 1'b0, 1'b0}, 1'b1,
                 {16'hFFFD, 8'hFD, 8'hFF, 1'b0});
        // clear phase never flags, even at a negative position
        add_step({CMD_CLEAR_PHASE, 7'd127, DIR_FWD, 1'b1, 1'b0}, 1'b1,
                 {16'hFFFD, 8'h00, 8'h00, 1'b0});
        add_step({CMD_STEP, 7'd0, DIR_FWD, 1'b1, 1'b0}, 1'b1,
                 {16'hFFFD, 8'h00, 8'h00, 1'b1});
        // bound of zero: every checked move flags
        add_reg(CFG_MAX_POSITION, 15'd0);
        add_step({CMD_STEP, 7'd3, DIR_FWD, 1'b1, 1'b0}, 1'b1,
                 {16'h0000, 8'h03, 8'h03, 1'b1});
        add_step({CMD_STEP, 7'd0, DIR_FWD, 1'b0, 1'b0}, 1'b1,
                 {16'h0000, 8'h03, 8'h00, 1'b0});
        add_reg(CFG_MAX_POSITION, 15'd1);
        add_step({CMD_STEP, 7'd0, DIR_FWD, 1'b1, 1'b0}, 1'b1,
                 {16'h0000, 8'h03, 8'h00, 1'b0});
        add_step({CMD_STEP, 7'd1, DIR_FWD, 1'b1, 1'b0}, 1'b1,
                 {16'h0001, 8'h04, 8'h01, 1'b1});
        add_reg(CFG_MAX_POSITION, 15'h7FFF);
        // widest dead zone: fill, overflow, reverse through it both ways
        add_reg(CFG_BACKLASH_WIDTH, 15'd127);
        add_step({CMD_STEP, 7'd127, DIR_FWD, 1'b1, 1'b0}, 1'b0, '0);
        add_step({CMD_STEP, 7'd5, DIR_FWD, 1'b1, 1'b0}, 1'b0, '0);
        add_step({CMD_STEP, 7'd127, DIR_BWD, 1'b1, 1'b0}, 1'b0, '0);
        add_step({CMD_STEP, 7'd1, DIR_BWD, 1'b1, 1'b0}, 1'b0, '0);
        add_step({CMD_STEP, 7'd127, DIR_FWD, 1'b1, 1'b0}, 1'b0, '0);
        add_step({CMD_STEP, 7'd1, DIR_BWD, 1'b1, 1'b0}, 1'b0, '0);
        // narrow zone with a stale offset left over from the wide one
        add_reg(CFG_BACKLASH_WIDTH, 15'd1);
        add_step({CMD_STEP, 7'd1, DIR_FWD, 1'b1, 1'b0}, 1'b0, '0);
        add_step({CMD_STEP, 7'd1, DIR_BWD, 1'b1, 1'b0}, 1'b0, '0);
        add_step({CMD_STEP, 7'd2, DIR_BWD, 1'b1, 1'b0}, 1'b0, '0);
        add_step({CMD_STEP, 7'd0, DIR_FWD, 1'b1, 1'b0}, 1'b0, '0);
        // compensation off leaves the offset alone
        add_reg(CFG_BACKLASH_WIDTH, 15'd0);
        add_step({CMD_STEP, 7'd127, DIR_FWD, 1'b1, 1'b1}, 1'b0, '0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_REG)
            begin
                wait_drained();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            end
            else
            begin
                send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
            end
        end

        // Random segments: new settings each time, runs of one direction with stray
        // reversals; every fourth segment is a long forward sprint to wrap the position
        seg = 0;
        sent = 0;
        run_left = 0;
        while (sent < RANDOM_WORDS)
        begin
            wait_drained();
            sprint = (seg % 4 == 1);
            calm = (seg == 2);
            case ($urandom_range(4))
                0: val = 15'd0;
                1: val = 15'd1;
                2: val = 15'd127;
                3: val = CFG_DATA_W'($urandom_range(1, 127));
                default: val = CFG_DATA_W'($urandom_range(1, 16));
            endcase
            write_reg(CFG_BACKLASH_WIDTH, val);
            case ($urandom_range(5))
                0: val = 15'd0;
                1: val = 15'd1;
                2: val = 15'h7FFF;
                3: val = CFG_DATA_W'($urandom_range(1, 32767));
                default: val = CFG_DATA_W'($urandom_range(1, 4000));
            endcase
            write_reg(CFG_MAX_POSITION, val);

            drift = sprint ? DIR_FWD : logic'($urandom_range(1));
            seg_len = sprint ? 450 : $urandom_range(120, 260);
            pause_at = $urandom_range(seg_len - 1);
            run_left = 0;
            for (int i = 0; i < seg_len && sent < RANDOM_WORDS; i++)
            begin
                if (i == pause_at)
                    wait_drained();
                if (run_left == 0)
                begin
                    run_left = $urandom_range(1, 16);
                    dir = ($urandom_range(99) < (sprint ? 90 : 65)) ? drift : !drift;
                    // half the runs use distances near the zone width
                    if (cfg_bw != 0 && $urandom_range(1) == 1)
                        cap = (2 * cfg_bw + 2 > 127) ? 127 : 2 * cfg_bw + 2;
                    else
                        cap = 127;
                end
                w.command = ($urandom_range(99) < 4) ? CMD_CLEAR_PHASE : CMD_STEP;
                w.step_dist = sprint ? DIST_W'($urandom_range(64, 127))
                                     : DIST_W'($urandom_range(cap));
                w.forward = ($urandom_range(99) < 6) ? !dir : dir;
                w.moving_normally = ($urandom_range(99) < 80);
                w.ignore_bounds = ($urandom_range(99) < 20);
                send_word(w, 1'b0, '0);
                sent++;
                run_left--;
            end
            seg++;
        end
        calm = 1'b0;

        // drain, then let the pipeline settle
        step_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("ran %0d step words and %0d phase clears over %0d segments, %0d register writes",
                 n_steps, n_clears, seg, n_writes);
        $display("checked %0d results: %0d bounds errors, %0d moves absorbed by the dead zone",
                 n_checked, n_errors, n_absorbed);
        if (mismatches == 0)
            $display("[backlash_position_tracker] OK");
        else
            $display("[backlash_position_tracker] ERROR");
        $finish;
    end

endmodule
